// ----- sv/rlpe_pkg.sv -----
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types, register codes and the gamma table for the RGB LED
// pulse-width encoder.
// ----------------------------------------------------------------------------
package rlpe_pkg;

    localparam int BITS_PER_SLOT = 24;
    localparam int DUTY_W        = 16;
    localparam int COLOR_W       = 8;
    localparam int CNT_W         = 5;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_SLOT - 1);

    // configuration register indexes
    localparam logic [1:0] CFG_ONE_DUTY   = 2'd0;
    localparam logic [1:0] CFG_ZERO_DUTY  = 2'd1;
    localparam logic [1:0] CFG_GAMMA_MODE = 2'd2;

    // gamma modes; the unused code behaves as GAMMA_NONE
    localparam logic [1:0] GAMMA_NONE   = 2'd0;
    localparam logic [1:0] GAMMA_TABLE  = 2'd1;
    localparam logic [1:0] GAMMA_SQUARE = 2'd2;

    // input opcode
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_NULL  = 1'b1;

    typedef struct packed {
        logic                     is_null;
        logic [BITS_PER_SLOT-1:0] grb;     // green, red, blue from the top bit down
    } slot_t;

    typedef struct packed {
        logic [DUTY_W-1:0] one;
        logic [DUTY_W-1:0] zero;
    } duty_cfg_t;

    localparam logic [7:0] GAMMA_LUT [256] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3,
        8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6,
        8'd6, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9,
        8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13, 8'd13, 8'd14,
        8'd14, 8'd15, 8'd15, 8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18, 8'd19,
        8'd19, 8'd20, 8'd20, 8'd21, 8'd21, 8'd22, 8'd23, 8'd23, 8'd24, 8'd24,
        8'd25, 8'd26, 8'd26, 8'd27, 8'd28, 8'd28, 8'd29, 8'd30, 8'd30, 8'd31,
        8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36, 8'd37, 8'd38, 8'd38,
        8'd39, 8'd40, 8'd41, 8'd42, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47,
        8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56,
        8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65,
        8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd73, 8'd74, 8'd75, 8'd76,
        8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd84, 8'd85, 8'd86, 8'd87,
        8'd88, 8'd89, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95, 8'd97, 8'd98, 8'd99,
        8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109, 8'd111, 8'd112,
        8'd113, 8'd115, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121, 8'd123, 8'd124, 8'd126,
        8'd127, 8'd128, 8'd130, 8'd131, 8'd133, 8'd134, 8'd136, 8'd137, 8'd139, 8'd140,
        8'd142, 8'd143, 8'd145, 8'd146, 8'd148, 8'd149, 8'd151, 8'd152, 8'd154, 8'd155,
        8'd157, 8'd158, 8'd160, 8'd162, 8'd163, 8'd165, 8'd166, 8'd168, 8'd170, 8'd171,
        8'd173, 8'd175, 8'd176, 8'd178, 8'd180, 8'd181, 8'd183, 8'd185, 8'd186, 8'd188,
        8'd190, 8'd192, 8'd193, 8'd195, 8'd197, 8'd199, 8'd200, 8'd202, 8'd204, 8'd206,
        8'd207, 8'd209, 8'd211, 8'd213, 8'd215, 8'd217, 8'd218, 8'd220, 8'd222, 8'd224,
        8'd226, 8'd228, 8'd230, 8'd232, 8'd233, 8'd235, 8'd237, 8'd239, 8'd241, 8'd243,
        8'd245, 8'd247, 8'd249, 8'd251, 8'd253, 8'd255
    };

endpackage

// ----- sv/rlpe_front.sv -----
// ----------------------------------------------------------------------------
// rlpe_front
// Classify incoming words as pixel or null slot, apply the gamma curve to
// each color and reorder the pixel into the green, red, blue bit order.
// ----------------------------------------------------------------------------
module rlpe_front
    import rlpe_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // pixel_color
    input  logic        s_tuser,     // opcode
    input  logic [1:0]  gamma_mode,
    output logic        push,
    input  logic        push_ready,
    output slot_t       push_slot
);

    function automatic logic [COLOR_W-1:0] apply_gamma(
        input logic [1:0]         mode,
        input logic [COLOR_W-1:0] v
    );
        logic [2*COLOR_W-1:0] sq;
        sq = (2*COLOR_W)'(v) * (2*COLOR_W)'(v) + (2*COLOR_W)'(v);
        unique case (mode)
            GAMMA_TABLE:  apply_gamma = GAMMA_LUT[v];
            GAMMA_SQUARE: apply_gamma = sq[2*COLOR_W-1:COLOR_W];
            default:      apply_gamma = v;
        endcase
    endfunction

    logic [COLOR_W-1:0] red, green, blue;

    assign red   = apply_gamma(gamma_mode, s_tdata[23:16]);
    assign green = apply_gamma(gamma_mode, s_tdata[15:8]);
    assign blue  = apply_gamma(gamma_mode, s_tdata[7:0]);

    assign s_tready          = push_ready;
    assign push              = s_tvalid && push_ready;
    assign push_slot.is_null = (s_tuser == OP_NULL);
    assign push_slot.grb     = {green, red, blue};

endmodule

// ----- sv/rlpe_queue.sv -----
// ----------------------------------------------------------------------------
// rlpe_queue
// Short slot queue between front and back; each side stalls on its own.
// ----------------------------------------------------------------------------
module rlpe_queue
    import rlpe_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  slot_t in_slot,
    output logic  out_valid,
    input  logic  out_ready,
    output slot_t out_slot
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL     = CNT_W_Q'(DEPTH);

    slot_t               entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0]  count_reg, count_next;
    logic                do_push, do_pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign out_slot  = entry_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= in_slot;
        end
    end

    no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("queue count beyond depth");

    pop_moves_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue pop did not drop count");

endmodule

// ----- sv/rlpe_back.sv -----
// ----------------------------------------------------------------------------
// rlpe_back
// Serialize one slot into 24 compare values, most significant bit first,
// through a registered output stage.
// ----------------------------------------------------------------------------
module rlpe_back
    import rlpe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop,
    input  slot_t             pop_slot,
    input  duty_cfg_t         duty_cfg,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DUTY_W-1:0] m_tdata,
    output logic              m_tlast
);

    logic [BITS_PER_SLOT-1:0] word_reg, word_next;
    logic                     null_reg, null_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]        out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;
    logic                     advance, at_last;

    assign advance = busy_reg && (!out_valid_reg || m_tready);
    assign at_last = (cnt_reg == LAST_BIT);
    assign pop     = pop_valid && (!busy_reg || (advance && at_last));

    always_comb begin
        word_next      = word_reg;
        null_next      = null_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_last_next  = at_last;
            if (null_reg) begin
                out_data_next = '0;
            end else begin
                out_data_next = word_reg[BITS_PER_SLOT-1] ? duty_cfg.one : duty_cfg.zero;
            end
            word_next = {word_reg[BITS_PER_SLOT-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        // load the next slot, overriding the shift on its final bit
        if (pop) begin
            word_next = pop_slot.grb;
            null_next = pop_slot.is_null;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        null_reg     <= null_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg <= LAST_BIT)
        else $error("bit counter past end of slot");

    last_marks_final_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_last_reg == ($past(cnt_reg) == LAST_BIT))
        else $error("last flag out of step with bit counter");

    pop_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!busy_reg || at_last))
        else $error("slot loaded over one in progress");

endmodule

// ----- sv/rgb_led_pulse_width_encoder.sv -----
// ----------------------------------------------------------------------------
// rgb_led_pulse_width_encoder
// Turn pixels and null slots into 24 timer compare values each.
// ----------------------------------------------------------------------------
// Path: a slot's input word is written into the queue, then loaded into the
//   serializer once it is free, then registered in the output stage.
// Throughput: one compare value per cycle while m_tready is high, set by the
//   one-bit-per-cycle serializer in the back end; input words queue ahead.
// Reset: synchronous, active low; empties the queue and serializer and
//   clears all three configuration registers to zero.
// ----------------------------------------------------------------------------
module rgb_led_pulse_width_encoder
    import rlpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] pixel_color
    input  logic        s_tuser,    // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] duty
    output logic        m_tlast,    // last_of_slot
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    // configuration registers
    logic [DUTY_W-1:0] one_duty_reg;
    logic [DUTY_W-1:0] zero_duty_reg;
    logic [1:0]        gamma_mode_reg;

    // front to queue, queue to back
    logic      push, push_ready;
    slot_t     push_slot;
    logic      pop_valid, pop;
    slot_t     pop_slot;
    duty_cfg_t duty_cfg;

    // Take register writes; drop writes to the unused index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_duty_reg   <= '0;
            zero_duty_reg  <= '0;
            gamma_mode_reg <= GAMMA_NONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ONE_DUTY:   one_duty_reg   <= cfg_wdata;
                CFG_ZERO_DUTY:  zero_duty_reg  <= cfg_wdata;
                CFG_GAMMA_MODE: gamma_mode_reg <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    assign duty_cfg.one  = one_duty_reg;
    assign duty_cfg.zero = zero_duty_reg;

    // Front: classify the word and apply gamma before it is queued.
    rlpe_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .gamma_mode (gamma_mode_reg),
        .push       (push),
        .push_ready (push_ready),
        .push_slot  (push_slot)
    );

    // Queue: hold slots while the back end is still sending earlier ones.
    rlpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (push_ready),
        .in_slot   (push_slot),
        .out_valid (pop_valid),
        .out_ready (pop),
        .out_slot  (pop_slot)
    );

    // Back: shift out one compare value per unstalled cycle, green first, MSB first.
    rlpe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_slot  (pop_slot),
        .duty_cfg  (duty_cfg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- tb/duty_check_pkg.sv -----
// ----------------------------------------------------------------------------
// duty_check_pkg
// Predicts the compare words of the RGB LED pulse-width encoder and checks
// them in order against the words that leave the block.
// ----------------------------------------------------------------------------
package duty_check_pkg;

    import rlpe_pkg::*;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              last;
    } duty_word_t;

    class duty_scoreboard;

        logic [DUTY_W-1:0] one_duty;
        logic [DUTY_W-1:0] zero_duty;
        logic [1:0]        gamma_sel;
        duty_word_t        expected_duties[$];
        int unsigned       mismatches;

        function new();
            one_duty   = '0;
            zero_duty  = '0;
            gamma_sel  = GAMMA_NONE;
            mismatches = 0;
        endfunction

        // Mirror a register write; index three has no register behind it.
        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_ONE_DUTY:   one_duty  = data;
                CFG_ZERO_DUTY:  zero_duty = data;
                CFG_GAMMA_MODE: gamma_sel = data[1:0];
                default: ;
            endcase
        endfunction

        // Undefined gamma code falls through to pass-through.
        function logic [COLOR_W-1:0] shape(logic [COLOR_W-1:0] v);
            logic [16:0] sq;
            case (gamma_sel)
                GAMMA_TABLE:  return GAMMA_LUT[v];
                GAMMA_SQUARE: begin
                    sq = v * v + v;
                    return sq[15:8];
                end
                default:      return v;
            endcase
        endfunction

        function void note_slot(logic op, logic [23:0] color);
            logic [BITS_PER_SLOT-1:0] grb;
            duty_word_t               w;
            grb = {shape(color[15:8]), shape(color[23:16]), shape(color[7:0])};
            for (int k = 0; k < BITS_PER_SLOT; k++) begin
                if (op == OP_NULL)
                    w.duty = '0;
                else
                    w.duty = grb[BITS_PER_SLOT-1-k] ? one_duty : zero_duty;
                w.last = (k == BITS_PER_SLOT - 1);
                expected_duties.push_back(w);
            end
        endfunction

        function void check_word(logic [DUTY_W-1:0] duty, logic last);
            duty_word_t w;
            if (expected_duties.size() == 0) begin
                $error("unexpected compare word: duty=%0d last_of_slot=%0d", duty, last);
                mismatches++;
                return;
            end
            w = expected_duties.pop_front();
            if (duty !== w.duty) begin
                $error("duty: expected %0d, actual %0d", w.duty, duty);
                mismatches++;
            end
            if (last !== w.last) begin
                $error("last_of_slot: expected %0d, actual %0d", w.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_duties.size();
        endfunction

    endclass

endpackage

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the RGB LED pulse-width encoder. Feeds pixels and null slots
// on the input stream under several duty and gamma settings, predicts the 24
// compare words of every accepted slot and checks each word taken from the
// result stream, with random idle bursts on both sides for most of the run.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rlpe_pkg::*;
    import duty_check_pkg::*;

    // register index with nothing behind it, and the undefined gamma code
    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam logic [1:0] GAMMA_SPARE = 2'd3;

    localparam int RANDOM_PHASES   = 8;
    localparam int SLOTS_PER_PHASE = 58;
    localparam int QUIET_PHASES    = 2;      // last phases run without idling
    localparam int LIMIT_CYCLES    = 1_000_000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;             // [23:0] pixel_color
    logic        s_tuser   = OP_PIXEL;       // [0] opcode
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [15:0] m_tdata;                    // [15:0] duty
    logic        m_tlast;                    // last_of_slot
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;

    // idling switches for the feeder and the sink
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    int unsigned    cycle_count = 0;
    duty_scoreboard slot_ledger = new();

    always #5 aclk = ~aclk;

    rgb_led_pulse_width_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Watch every port at the edge: mirror register writes, predict each
    // accepted slot, check each accepted compare word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                slot_ledger.write_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                slot_ledger.note_slot(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                slot_ledger.check_word(m_tdata, m_tlast);
        end
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sink: drop tready for a random burst now and then.
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Program all three registers, optionally poking the spare index as well.
    // Hold the write enable across the writes and drop it once at the end.
    task automatic program_regs(input logic [15:0] one, input logic [15:0] zero,
                                input logic [1:0] gamma, input bit poke_spare,
                                input logic [15:0] spare_data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_ONE_DUTY;
        cfg_wdata <= one;
        @(posedge aclk);
        cfg_addr  <= CFG_ZERO_DUTY;
        cfg_wdata <= zero;
        @(posedge aclk);
        cfg_addr  <= CFG_GAMMA_MODE;
        cfg_wdata <= {14'd0, gamma};
        @(posedge aclk);
        if (poke_spare) begin
            cfg_addr  <= CFG_SPARE;
            cfg_wdata <= spare_data;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one slot word and hold it until taken. An idle gap may come first;
    // tvalid is only lowered when a gap follows, never between two words.
    task automatic send_slot(input logic op, input logic [23:0] color);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= color;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and wait until every predicted compare word has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (slot_ledger.pending() != 0);
    endtask

    // Channel values lean toward the extremes.
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_duty();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        logic [23:0] color;
        logic        op;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: both duties zero, so every pixel bit comes out as zero.
        send_slot(OP_PIXEL, 24'hFFFFFF);
        send_slot(OP_PIXEL, 24'h5A5A5A);
        drain();

        // Full-scale one duty, gamma off: check bit order and the channel swap.
        program_regs(16'hFFFF, 16'h0000, GAMMA_NONE, 1'b0, '0);
        send_slot(OP_PIXEL, 24'h000000);
        send_slot(OP_PIXEL, 24'hFFFFFF);
        send_slot(OP_PIXEL, 24'hAA55F0);
        send_slot(OP_PIXEL, 24'h800001);
        // null slots ignore the color entirely
        send_slot(OP_NULL,  24'hFFFFFF);
        send_slot(OP_NULL,  24'h000000);
        drain();

        // Swapped duties through the gamma table, including its flat low end.
        program_regs(16'h0000, 16'hFFFF, GAMMA_TABLE, 1'b0, '0);
        send_slot(OP_PIXEL, 24'hFFFFFF);
        send_slot(OP_PIXEL, 24'h0C0B80);
        send_slot(OP_PIXEL, 24'h7F8001);
        drain();

        // Squared curve.
        program_regs(16'h1234, 16'h00FF, GAMMA_SQUARE, 1'b0, '0);
        send_slot(OP_PIXEL, 24'hFF0F10);
        send_slot(OP_PIXEL, 24'h010203);
        send_slot(OP_PIXEL, 24'h808080);
        send_slot(OP_NULL,  24'h123456);
        drain();

        // Undefined gamma code passes colors through unchanged.
        program_regs(16'hFFFF, 16'h0001, GAMMA_SPARE, 1'b0, '0);
        send_slot(OP_PIXEL, 24'h123456);
        send_slot(OP_PIXEL, 24'hFFFFFF);
        drain();

        // A write to the spare index must leave every register alone.
        program_regs(16'hC3C3, 16'h3C3C, GAMMA_TABLE, 1'b1, 16'hFFFF);
        send_slot(OP_PIXEL, 24'hA5A5A5);
        send_slot(OP_PIXEL, 24'h00FF00);
        drain();

        // Random phases, each under a fresh setting; the last ones run flat out.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase >= RANDOM_PHASES - QUIET_PHASES) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            program_regs(pick_duty(), pick_duty(), 2'($urandom_range(0, 3)),
                         $urandom_range(0, 3) == 0, 16'($urandom_range(0, 65535)));
            for (int n = 0; n < SLOTS_PER_PHASE; n++) begin
                op    = ($urandom_range(0, 6) == 0) ? OP_NULL : OP_PIXEL;
                color = {pick_channel(), pick_channel(), pick_channel()};
                send_slot(op, color);
            end
            drain();
        end

        // Give a stray word time to show up.
        repeat (8) @(posedge aclk);

        if (slot_ledger.mismatches == 0 && slot_ledger.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rlpe_pkg.sv
sv/rlpe_front.sv
sv/rlpe_queue.sv
sv/rlpe_back.sv
sv/rgb_led_pulse_width_encoder.sv
tb/duty_check_pkg.sv
tb/tb_top.sv
